/* sv/assert_macros.svh */
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent implies consequent in the same cycle.
`define AST_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Antecedent implies consequent in the next cycle.
`define AST_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

/* sv/mhs_pkg.sv */
// Types, constants and modular arithmetic helpers for the MinHash sketch.
package mhs_pkg;

    localparam logic [62:0] HASH_MOD = 63'h7FFF_FFFF_FFFF_FFE7;
    localparam logic [63:0] C_GOLDEN = 64'h9E37_79B9_7F4A_7C15;
    localparam logic [63:0] C_MIX1   = 64'hBF58_476D_1CE4_E5B9;
    localparam logic [63:0] C_MIX2   = 64'h94D0_49BB_1331_11EB;
    localparam logic [6:0]  RUN_MAX  = 7'd127;
    localparam logic [7:0]  PAD_LO   = 8'h00;
    localparam logic [7:0]  PAD_HI   = 8'hFF;

    typedef enum logic [1:0] {
        ACT_CLEAR = 2'd0,
        ACT_FEED  = 2'd1,
        ACT_READ  = 2'd2
    } t_action;

    typedef enum logic [4:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_F0,
        ST_F1,
        ST_F2,
        ST_MIX_PRE,
        ST_M1A,
        ST_M1B,
        ST_M1C,
        ST_MIX_MID,
        ST_M2A,
        ST_M2B,
        ST_M2C,
        ST_MIX_END,
        ST_OFF_RD,
        ST_OFF_UPD,
        ST_RD_ADDR,
        ST_RD_OUT
    } t_state;

    typedef enum logic [3:0] {
        DP_NOP,
        DP_CLEAR_STATE,
        DP_CLR_WR,
        DP_FEED_A,
        DP_FEED_B,
        DP_FEED_C,
        DP_MIX_PRE,
        DP_MUL_LO,
        DP_MUL_X1,
        DP_MUL_X2,
        DP_MIX_MID,
        DP_MIX_END,
        DP_OFF_RD,
        DP_OFF_UPD,
        DP_READ_RD,
        DP_OUT_LOAD
    } t_dp_op;

    typedef struct packed {
        t_dp_op op;
        logic   take;   // latch input fields
        logic   ksel;   // 0: first mix constant, 1: second
    } t_dp_cmd;

    typedef struct packed {
        logic offer;
        logic clr_last;
        logic out_free;
    } t_dp_status;

    // 31*h mod M, h < M; 2^63 is congruent to 25.
    function automatic logic [62:0] mod_mul31(input logic [62:0] h);
        logic [67:0] t;
        logic [63:0] s;
        t = {h, 5'b0} - {5'b0, h};
        s = {1'b0, t[62:0]} + 64'(t[67:63]) * 64'd25;
        if (s >= {1'b0, HASH_MOD}) s = s - {1'b0, HASH_MOD};
        return s[62:0];
    endfunction

    // p*w mod M for p < M and an 8-bit w.
    function automatic logic [62:0] mod_mul_byte(input logic [62:0] p, input logic [7:0] w);
        logic [70:0] t;
        logic [63:0] s;
        t = 71'(p) * 71'(w);
        s = {1'b0, t[62:0]} + 64'(t[70:63]) * 64'd25;
        if (s >= {1'b0, HASH_MOD}) s = s - {1'b0, HASH_MOD};
        return s[62:0];
    endfunction

    function automatic logic [62:0] mod_add(input logic [62:0] a, input logic [62:0] b);
        logic [63:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= {1'b0, HASH_MOD}) s = s - {1'b0, HASH_MOD};
        return s[62:0];
    endfunction

    function automatic logic [62:0] mod_neg(input logic [62:0] a);
        return (a == 63'd0) ? 63'd0 : HASH_MOD - a;
    endfunction

    // 31^n mod M, evaluated at elaboration only.
    function automatic logic [62:0] pow31(input int n);
        logic [62:0] p;
        p = 63'd1;
        for (int i = 0; i < n; i++) p = mod_mul31(p);
        return p;
    endfunction

endpackage

/* sv/mhs_ram.sv */
// Generic simple dual-port RAM with registered read.
module mhs_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
        if (i_re) r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* sv/mhs_ctrl.sv */
// Sequencer for clear, feed, mix and read steps of the sketch.
module mhs_ctrl (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    input  logic [1:0]             i_action,
    output logic                   o_in_stall,
    output mhs_pkg::t_dp_cmd       o_cmd,
    input  mhs_pkg::t_dp_status    i_status
);

    mhs_pkg::t_state r_state, n_state;

    // Hold state; reset starts the clearing pass.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= mhs_pkg::ST_CLEAR;
        else          r_state <= n_state;
    end

    // Decide next state and datapath command.
    always_comb begin
        n_state    = r_state;
        o_cmd.op   = mhs_pkg::DP_NOP;
        o_cmd.take = 1'b0;
        o_cmd.ksel = 1'b0;
        o_in_stall = (r_state != mhs_pkg::ST_IDLE);
        unique case (r_state)
            mhs_pkg::ST_CLEAR: begin
                o_cmd.op = mhs_pkg::DP_CLR_WR;
                if (i_status.clr_last) n_state = mhs_pkg::ST_IDLE;
            end
            mhs_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.take = 1'b1;
                    unique case (i_action)
                        mhs_pkg::ACT_CLEAR: begin
                            o_cmd.op = mhs_pkg::DP_CLEAR_STATE;
                            n_state  = mhs_pkg::ST_CLEAR;
                        end
                        mhs_pkg::ACT_FEED: n_state = mhs_pkg::ST_F0;
                        mhs_pkg::ACT_READ: n_state = mhs_pkg::ST_RD_ADDR;
                        default:           n_state = mhs_pkg::ST_IDLE;
                    endcase
                end
            end
            mhs_pkg::ST_F0: begin
                o_cmd.op = mhs_pkg::DP_FEED_A;
                n_state  = mhs_pkg::ST_F1;
            end
            mhs_pkg::ST_F1: begin
                o_cmd.op = mhs_pkg::DP_FEED_B;
                n_state  = mhs_pkg::ST_F2;
            end
            mhs_pkg::ST_F2: begin
                o_cmd.op = mhs_pkg::DP_FEED_C;
                n_state  = i_status.offer ? mhs_pkg::ST_MIX_PRE : mhs_pkg::ST_IDLE;
            end
            mhs_pkg::ST_MIX_PRE: begin
                o_cmd.op = mhs_pkg::DP_MIX_PRE;
                n_state  = mhs_pkg::ST_M1A;
            end
            mhs_pkg::ST_M1A: begin
                o_cmd.op = mhs_pkg::DP_MUL_LO;
                n_state  = mhs_pkg::ST_M1B;
            end
            mhs_pkg::ST_M1B: begin
                o_cmd.op = mhs_pkg::DP_MUL_X1;
                n_state  = mhs_pkg::ST_M1C;
            end
            mhs_pkg::ST_M1C: begin
                o_cmd.op = mhs_pkg::DP_MUL_X2;
                n_state  = mhs_pkg::ST_MIX_MID;
            end
            mhs_pkg::ST_MIX_MID: begin
                o_cmd.op = mhs_pkg::DP_MIX_MID;
                n_state  = mhs_pkg::ST_M2A;
            end
            mhs_pkg::ST_M2A: begin
                o_cmd.op   = mhs_pkg::DP_MUL_LO;
                o_cmd.ksel = 1'b1;
                n_state    = mhs_pkg::ST_M2B;
            end
            mhs_pkg::ST_M2B: begin
                o_cmd.op   = mhs_pkg::DP_MUL_X1;
                o_cmd.ksel = 1'b1;
                n_state    = mhs_pkg::ST_M2C;
            end
            mhs_pkg::ST_M2C: begin
                o_cmd.op   = mhs_pkg::DP_MUL_X2;
                o_cmd.ksel = 1'b1;
                n_state    = mhs_pkg::ST_MIX_END;
            end
            mhs_pkg::ST_MIX_END: begin
                o_cmd.op = mhs_pkg::DP_MIX_END;
                n_state  = mhs_pkg::ST_OFF_RD;
            end
            mhs_pkg::ST_OFF_RD: begin
                o_cmd.op = mhs_pkg::DP_OFF_RD;
                n_state  = mhs_pkg::ST_OFF_UPD;
            end
            mhs_pkg::ST_OFF_UPD: begin
                o_cmd.op = mhs_pkg::DP_OFF_UPD;
                n_state  = mhs_pkg::ST_IDLE;
            end
            mhs_pkg::ST_RD_ADDR: begin
                o_cmd.op = mhs_pkg::DP_READ_RD;
                n_state  = mhs_pkg::ST_RD_OUT;
            end
            mhs_pkg::ST_RD_OUT: begin
                // Wait for the output register to free up.
                if (i_status.out_free) begin
                    o_cmd.op = mhs_pkg::DP_OUT_LOAD;
                    n_state  = mhs_pkg::ST_IDLE;
                end
            end
            default: n_state = mhs_pkg::ST_CLEAR;
        endcase
    end

endmodule

/* sv/mhs_dp.sv */
// Datapath: rolling hash, window, mixer, bucket memory and result register.
module mhs_dp #(
    parameter int BUCKETS = 128,
    parameter int SHINGLE = 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  mhs_pkg::t_dp_cmd      i_cmd,
    output mhs_pkg::t_dp_status   o_status,
    input  logic [7:0]            i_data_byte,
    input  logic [6:0]            i_bucket_index,
    input  logic                  i_out_stall,
    output logic                  o_out_valid,
    output logic [63:0]           o_bucket_value,
    output logic [31:0]           o_bytes_seen
);

    localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam int IW = (BW > 7) ? BW : 7;
    localparam logic [62:0] POW = mhs_pkg::pow31(SHINGLE);

    logic [7:0]    r_win [SHINGLE];
    logic [7:0]    r_byte;
    logic [BW-1:0] r_idx;
    logic [62:0]   r_hash;
    logic [62:0]   r_h31;
    logic [62:0]   r_out;
    logic [6:0]    r_run;
    logic [31:0]   r_count;
    logic          r_offer;
    logic [63:0]   r_x;
    logic [63:0]   r_acc;
    logic [63:0]   r_f;
    logic [BW-1:0] r_clr;
    logic          r_ovalid;
    logic [63:0]   r_oval;
    logic [31:0]   r_ocnt;

    logic [IW-1:0] idx_ext;
    logic [31:0]   n_count;
    logic [6:0]    n_run;
    logic          full_before;
    logic [63:0]   k;
    logic [31:0]   mul_a, mul_b;
    logic [63:0]   prod;
    logic [63:0]   x_pre, f_mix;
    logic          clear_now;
    logic          ram_we, ram_re;
    logic [BW-1:0] ram_waddr, ram_raddr;
    logic [63:0]   ram_wdata, ram_rdata;
    logic          out_free;

    assign idx_ext   = IW'(i_bucket_index);
    assign clear_now = (i_cmd.op == mhs_pkg::DP_CLEAR_STATE);

    // Update run length and byte count for the incoming byte.
    always_comb begin
        full_before = (r_count >= 32'(SHINGLE));
        n_count     = (r_count == 32'hFFFF_FFFF) ? r_count : r_count + 32'd1;
        if (r_count != 32'd0 && r_win[SHINGLE-1] == r_byte)
            n_run = (r_run < mhs_pkg::RUN_MAX) ? r_run + 7'd1 : r_run;
        else
            n_run = 7'd1;
    end

    // Share one 32x32 multiplier over the three partial products.
    always_comb begin
        k = i_cmd.ksel ? mhs_pkg::C_MIX2 : mhs_pkg::C_MIX1;
        unique case (i_cmd.op)
            mhs_pkg::DP_MUL_X1: begin
                mul_a = r_x[63:32];
                mul_b = k[31:0];
            end
            mhs_pkg::DP_MUL_X2: begin
                mul_a = r_x[31:0];
                mul_b = k[63:32];
            end
            default: begin
                mul_a = r_x[31:0];
                mul_b = k[31:0];
            end
        endcase
        prod  = 64'(mul_a) * 64'(mul_b);
        x_pre = {1'b0, r_hash} + mhs_pkg::C_GOLDEN;
        f_mix = r_acc ^ (r_acc >> 31);
    end

    // Control state: hash, run, count, clear sweep, offer flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || clear_now) begin
            r_hash  <= '0;
            r_run   <= 7'd1;
            r_count <= '0;
            r_clr   <= '0;
            r_offer <= 1'b0;
        end else begin
            unique case (i_cmd.op)
                mhs_pkg::DP_CLR_WR: r_clr <= r_clr + BW'(1);
                mhs_pkg::DP_FEED_A: begin
                    r_run   <= n_run;
                    r_count <= n_count;
                    r_offer <= (n_count >= 32'(SHINGLE)) &&
                               !((n_run >= 7'(SHINGLE)) &&
                                 (r_byte == mhs_pkg::PAD_LO || r_byte == mhs_pkg::PAD_HI));
                end
                mhs_pkg::DP_FEED_C: r_hash <= mhs_pkg::mod_add(r_h31, 63'(r_byte));
                default: ;
            endcase
        end
    end

    // Result register: load on read, drop when taken.
    assign out_free = !r_ovalid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.op == mhs_pkg::DP_OUT_LOAD) begin
            r_ovalid <= 1'b1;
        end else if (!i_out_stall) begin
            r_ovalid <= 1'b0;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_byte <= i_data_byte;
            r_idx  <= idx_ext[BW-1:0];
        end
        unique case (i_cmd.op)
            mhs_pkg::DP_FEED_A: begin
                r_h31 <= mhs_pkg::mod_mul31(r_hash);
                r_out <= full_before ? mhs_pkg::mod_mul_byte(POW, r_win[0]) : 63'd0;
                for (int i = 0; i < SHINGLE - 1; i++) r_win[i] <= r_win[i+1];
                r_win[SHINGLE-1] <= r_byte;
            end
            mhs_pkg::DP_FEED_B:  r_h31 <= mhs_pkg::mod_add(r_h31, mhs_pkg::mod_neg(r_out));
            mhs_pkg::DP_MIX_PRE: r_x   <= x_pre ^ (x_pre >> 30);
            mhs_pkg::DP_MUL_LO:  r_acc <= prod;
            mhs_pkg::DP_MUL_X1,
            mhs_pkg::DP_MUL_X2:  r_acc[63:32] <= r_acc[63:32] + prod[31:0];
            mhs_pkg::DP_MIX_MID: r_x   <= r_acc ^ (r_acc >> 27);
            mhs_pkg::DP_MIX_END: r_f   <= (f_mix == 64'd0) ? 64'd1 : f_mix;
            mhs_pkg::DP_OUT_LOAD: begin
                r_oval <= ram_rdata;
                r_ocnt <= r_count;
            end
            default: ;
        endcase
    end

    // Bucket memory port control.
    always_comb begin
        ram_we    = 1'b0;
        ram_re    = 1'b0;
        ram_waddr = r_f[BW-1:0];
        ram_raddr = r_f[BW-1:0];
        ram_wdata = r_f;
        unique case (i_cmd.op)
            mhs_pkg::DP_CLR_WR: begin
                ram_we    = 1'b1;
                ram_waddr = r_clr;
                ram_wdata = '0;
            end
            mhs_pkg::DP_OFF_RD: ram_re = 1'b1;
            mhs_pkg::DP_OFF_UPD:
                ram_we = (ram_rdata == 64'd0) || (ram_rdata > r_f);
            mhs_pkg::DP_READ_RD: begin
                ram_re    = 1'b1;
                ram_raddr = r_idx;
            end
            default: ;
        endcase
    end

    mhs_ram #(
        .WIDTH (64),
        .DEPTH (1 << BW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign o_status.offer    = r_offer;
    assign o_status.clr_last = (r_clr == {BW{1'b1}});
    assign o_status.out_free = out_free;

    assign o_out_valid    = r_ovalid;
    assign o_bucket_value = r_oval;
    assign o_bytes_seen   = r_ocnt;

endmodule

/* sv/minhash_shingle_sketch.sv */
// Top level of the streaming MinHash shingle sketch.
// Input channel: i_in_valid / o_in_stall carry an action, a data byte and a
// bucket index. Action clear empties every bucket and restarts the stream,
// feed hashes one byte into the rolling window, read returns one bucket.
// Output channel: o_out_valid / i_out_stall carry the bucket value and the
// saturating byte count; only a read item produces an output item.
// Feed holds the input, taking no new byte until it is done: through F0, F1
// and F2 when no shingle is offered; when one is, also while the SplitMix64
// finalizer runs two 64-bit multiplies through one shared 32x32 multiplier,
// three partial products each, then a read-compare-write of the bucket memory.
// Read passes through RD_ADDR, which reads the bucket memory, and RD_OUT,
// which loads the output register once it is free. Clear holds the input
// while the bucket memory is swept one entry per cycle. Reset runs the same
// sweep, with o_in_stall high.
// The output register holds a finished result while i_out_stall is high;
// a further read item then waits before loading and holds off the input.
module minhash_shingle_sketch #(
    parameter int BUCKETS = 128,
    parameter int SHINGLE = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_action,
    input  logic [7:0]  i_data_byte,
    input  logic [6:0]  i_bucket_index,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [63:0] o_bucket_value,
    output logic [31:0] o_bytes_seen
);

    mhs_pkg::t_dp_cmd    cmd;
    mhs_pkg::t_dp_status status;

    mhs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_action   (i_action),
        .o_in_stall (o_in_stall),
        .o_cmd      (cmd),
        .i_status   (status)
    );

    mhs_dp #(
        .BUCKETS (BUCKETS),
        .SHINGLE (SHINGLE)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_status       (status),
        .i_data_byte    (i_data_byte),
        .i_bucket_index (i_bucket_index),
        .i_out_stall    (i_out_stall),
        .o_out_valid    (o_out_valid),
        .o_bucket_value (o_bucket_value),
        .o_bytes_seen   (o_bytes_seen)
    );

endmodule

/* sv/mhs_checker.sv */
// Port-level checker for the MinHash sketch, bound to the top level.
`include "assert_macros.svh"

module mhs_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_stall,
    input logic [1:0]  i_action,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [63:0] o_bucket_value,
    input logic [31:0] o_bytes_seen
);

    logic take_feed, take_read;

    assign take_feed = i_in_valid && !o_in_stall && (i_action == mhs_pkg::ACT_FEED);
    assign take_read = i_in_valid && !o_in_stall && (i_action == mhs_pkg::ACT_READ);

    // A stalled result holds.
    `AST_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_bucket_value) && $stable(o_bytes_seen))
    // Reset drops any result and starts the clearing sweep.
    `AST_NEXT(a_rst_state, i_clk, 1'b1, !i_rst_n, !o_out_valid && o_in_stall)
    // A fed byte keeps the block busy on the next cycle.
    `AST_NEXT(a_feed_busy, i_clk, i_rst_n, take_feed, o_in_stall)
    // A read item keeps the block busy and produces no result at once.
    `AST_NEXT(a_read_busy, i_clk, i_rst_n, take_read && !o_out_valid, o_in_stall && !o_out_valid)

endmodule

bind minhash_shingle_sketch mhs_checker u_mhs_checker (.*);
